// ----- rtl/row_softmax_causal_mask_defines.svh -----
// Assertion helpers for the row softmax block.
`ifndef ROW_SOFTMAX_CAUSAL_MASK_DEFINES_SVH
`define ROW_SOFTMAX_CAUSAL_MASK_DEFINES_SVH

// Implication check under the active-low reset.
`define RSM_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check under the active-low reset.
`define RSM_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rsm_pkg.sv -----
package rsm_pkg;

    localparam int MAX_LEN_DEF         = 64;
    localparam int EXP_TABLE_DEPTH_DEF = 256;
    localparam int SCORE_W             = 16;
    localparam int PROB_W              = 16;
    localparam int ROW_W               = 6;
    localparam int PAST_W              = 6;
    localparam int SUM_W               = 23;
    localparam int RECIP_W             = 33;
    localparam int ADDR_W              = 3;

    localparam logic [ADDR_W-1:0] REG_CAUSAL_MASK = 3'd0;
    localparam logic [ADDR_W-1:0] REG_PAST_LENGTH = 3'd4;

    localparam logic signed [SCORE_W-1:0] MINUS_INF = 16'sh8000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAX,
        ST_SUM,
        ST_DIV,
        ST_EMIT
    } back_state_t;

    // Row descriptor handed from the front end to the back end.
    typedef struct packed {
        logic [6:0] total;
        logic [6:0] counted;
    } row_desc_t;

    // exp(-i/16) in Q0.16, entry 0 saturated.
    function automatic logic [PROB_W-1:0] exp_entry(input int idx);
        logic [63:0] p;
        logic [63:0] e;
        p = 64'd1 << 32;
        for (int k = 0; k < 4096; k++)
        begin
            if (k < idx)
            begin
                p = (p * 64'd4034748383 + (64'd1 << 31)) >> 32;
            end
        end
        e = (p + 64'd32768) >> 16;
        return (e > 64'd65535) ? 16'hFFFF : e[PROB_W-1:0];
    endfunction

endpackage

// ----- rtl/rsm_stream_if.sv -----
interface rsm_stream_if #(
    parameter int DATA_W = 23
);
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/rsm_ram.sv -----
module rsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/rsm_divider.sv -----
// Restoring divider: quotient = floor(2^32 / divisor), one bit per cycle.
module rsm_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rsm_pkg::SUM_W-1:0]   divisor,
    output logic                        done,
    output logic [rsm_pkg::RECIP_W-1:0] quotient
);
    localparam int CNT_W = $clog2(rsm_pkg::RECIP_W + 1);

    logic [rsm_pkg::SUM_W:0]     rem_reg;
    logic [rsm_pkg::RECIP_W-1:0] quo_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic [rsm_pkg::SUM_W:0]     trial;
    logic                        bit_in;

    // dividend bits: a one then 32 zeros
    assign bit_in = (cnt_reg == CNT_W'(rsm_pkg::RECIP_W));
    assign trial  = {rem_reg[rsm_pkg::SUM_W-1:0], bit_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(rsm_pkg::RECIP_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_reg <= trial - {1'b0, divisor};
                quo_reg <= {quo_reg[rsm_pkg::RECIP_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[rsm_pkg::RECIP_W-2:0], 1'b0};
            end
        end
    end

    assign quotient = quo_reg;
endmodule

// ----- rtl/rsm_front.sv -----
`include "row_softmax_causal_mask_defines.svh"

// Loads scores into the store and posts a row descriptor on the last score.
module rsm_front #(
    parameter int MAX_LEN = rsm_pkg::MAX_LEN_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        causal_mask,
    input  logic [rsm_pkg::PAST_W-1:0]  past_length,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [rsm_pkg::SCORE_W-1:0] score,
    input  logic [rsm_pkg::ROW_W-1:0]   row_index,
    input  logic                        last,
    output logic                        wr_en,
    output logic [$clog2(MAX_LEN)-1:0]  wr_addr,
    output logic [rsm_pkg::SCORE_W-1:0] wr_data,
    output logic                        desc_valid,
    output rsm_pkg::row_desc_t          desc,
    input  logic                        back_busy
);
    logic [6:0] count_reg;
    logic [6:0] count_next;
    logic       full;
    logic [7:0] lim;
    logic       accept;

    assign full     = (count_reg >= 7'(MAX_LEN));
    // store is single-row: hold input while the back end owns it
    assign in_ready = !back_busy;
    assign accept   = in_valid && in_ready;
    assign wr_en    = accept && !full;
    assign wr_addr  = count_reg[$clog2(MAX_LEN)-1:0];
    assign wr_data  = score;

    always_comb
    begin
        count_next = full ? count_reg : count_reg + 1'b1;
        lim = 8'(row_index) + 8'd1 + 8'(past_length);
        desc.total   = count_next;
        desc.counted = count_next;
        if (causal_mask && (lim < 8'(count_next)))
        begin
            desc.counted = lim[6:0];
        end
    end

    assign desc_valid = accept && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= last ? 7'd0 : count_next;
        end
    end

    `RSM_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= 7'(MAX_LEN),
        "element count overflow")
    `RSM_ASSERT_IMP(a_desc_order, clk, rst_n, desc_valid,
        desc.counted <= desc.total, "counted exceeds loaded")
    `RSM_ASSERT_NEXT(a_count_clear, clk, rst_n, desc_valid, count_reg == 7'd0,
        "count not cleared after row")
endmodule

// ----- rtl/rsm_back.sv -----
`include "row_softmax_causal_mask_defines.svh"

// Runs max, sum, reciprocal and emission passes over one stored row.
module rsm_back #(
    parameter int MAX_LEN         = rsm_pkg::MAX_LEN_DEF,
    parameter int EXP_TABLE_DEPTH = rsm_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        desc_valid,
    input  rsm_pkg::row_desc_t          desc,
    output logic                        busy,
    output logic [$clog2(MAX_LEN)-1:0]  rd_addr,
    input  logic [rsm_pkg::SCORE_W-1:0] rd_data,
    rsm_stream_if.source                out_ch
);
    localparam int AW = $clog2(MAX_LEN);
    localparam int TW = $clog2(EXP_TABLE_DEPTH);

    logic [rsm_pkg::PROB_W-1:0] exp_rom [EXP_TABLE_DEPTH];
    for (genvar g = 0; g < EXP_TABLE_DEPTH; g++)
    begin : g_rom
        assign exp_rom[g] = rsm_pkg::exp_entry(g);
    end

    rsm_pkg::back_state_t state_reg, state_next;
    rsm_pkg::row_desc_t   desc_reg;
    logic                 desc_q_reg;
    logic [6:0]           idx_reg, idx_next;
    logic                 rd_v_reg, rd_v_next;
    logic [6:0]           rd_i_reg;
    logic signed [rsm_pkg::SCORE_W-1:0] max_reg;
    logic [rsm_pkg::SUM_W-1:0]   sum_reg;
    logic [rsm_pkg::RECIP_W-1:0] recip_reg;
    logic                        div_start;
    logic                        div_done;
    logic [rsm_pkg::RECIP_W-1:0] div_q;
    logic [rsm_pkg::PROB_W-1:0]  ev;
    logic [16:0]                 diff;
    logic [11:0]                 tidx;
    logic [49:0]                 prod;
    logic [33:0]                 pr;
    logic                        ob_full_reg;
    logic [rsm_pkg::PROB_W:0]    ob_reg;
    logic                        can_push;
    logic signed [rsm_pkg::SCORE_W-1:0] sc;

    assign sc = rd_data;
    assign busy = desc_q_reg || (state_reg != rsm_pkg::ST_IDLE);

    always_comb
    begin
        diff = 17'(max_reg) - 17'(sc);
        tidx = 12'(diff[15:4]);
        if (sc == rsm_pkg::MINUS_INF || tidx >= 12'(EXP_TABLE_DEPTH))
        begin
            ev = '0;
        end
        else
        begin
            ev = exp_rom[tidx[TW-1:0]];
        end
    end

    assign prod = 50'(ev) * 50'(recip_reg);
    assign pr = 34'((prod + 50'd32768) >> 16);

    assign can_push = !ob_full_reg || out_ch.ready;

    rsm_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (sum_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        rd_v_next  = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            rsm_pkg::ST_IDLE:
            begin
                idx_next = '0;
                if (desc_q_reg)
                begin
                    state_next = rsm_pkg::ST_MAX;
                end
            end
            rsm_pkg::ST_MAX, rsm_pkg::ST_SUM:
            begin
                if (idx_reg < desc_reg.counted)
                begin
                    rd_v_next = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
                else if (!rd_v_reg)
                begin
                    idx_next = '0;
                    if (state_reg == rsm_pkg::ST_MAX)
                    begin
                        state_next = rsm_pkg::ST_SUM;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = rsm_pkg::ST_DIV;
                    end
                end
            end
            rsm_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = rsm_pkg::ST_EMIT;
                end
            end
            rsm_pkg::ST_EMIT:
            begin
                // one read in flight at a time keeps the out buffer simple
                if (!rd_v_reg && can_push)
                begin
                    if (idx_reg < desc_reg.total)
                    begin
                        rd_v_next = 1'b1;
                        idx_next  = idx_reg + 1'b1;
                    end
                    else
                    begin
                        state_next = rsm_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = rsm_pkg::ST_IDLE;
            end
        endcase
    end

    assign rd_addr = idx_reg[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rsm_pkg::ST_IDLE;
            desc_q_reg  <= 1'b0;
            idx_reg     <= '0;
            rd_v_reg    <= 1'b0;
            ob_full_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            rd_v_reg  <= rd_v_next;
            if (desc_valid)
            begin
                desc_q_reg <= 1'b1;
            end
            else if (state_reg == rsm_pkg::ST_IDLE)
            begin
                desc_q_reg <= 1'b0;
            end
            if (rd_v_reg && state_reg == rsm_pkg::ST_EMIT)
            begin
                ob_full_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                ob_full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_i_reg <= idx_reg;
        if (desc_valid)
        begin
            desc_reg <= desc;
        end
        if (state_reg == rsm_pkg::ST_IDLE)
        begin
            max_reg <= rsm_pkg::MINUS_INF;
            sum_reg <= '0;
        end
        else if (rd_v_reg && state_reg == rsm_pkg::ST_MAX)
        begin
            if (sc > max_reg)
            begin
                max_reg <= sc;
            end
        end
        else if (rd_v_reg && state_reg == rsm_pkg::ST_SUM)
        begin
            sum_reg <= sum_reg + rsm_pkg::SUM_W'(ev);
        end
        if (div_done)
        begin
            recip_reg <= (sum_reg == '0) ? '0 : div_q;
        end
        if (rd_v_reg && state_reg == rsm_pkg::ST_EMIT)
        begin
            ob_reg[rsm_pkg::PROB_W] <= (rd_i_reg + 1'b1 == desc_reg.total);
            if (rd_i_reg >= desc_reg.counted)
            begin
                ob_reg[rsm_pkg::PROB_W-1:0] <= '0;
            end
            else
            begin
                ob_reg[rsm_pkg::PROB_W-1:0] <= (pr > 34'd65535) ? 16'hFFFF : pr[15:0];
            end
        end
    end

    assign out_ch.valid = ob_full_reg;
    assign out_ch.data  = ob_reg;

    `RSM_ASSERT_IMP(a_start_idle, clk, rst_n, div_start,
        state_reg == rsm_pkg::ST_SUM, "divider started outside sum pass")
    `RSM_ASSERT_IMP(a_out_in_emit, clk, rst_n, rd_v_reg && state_reg == rsm_pkg::ST_EMIT,
        can_push || !ob_full_reg || out_ch.ready, "emit overruns out buffer")
    `RSM_ASSERT_NEXT(a_done_emit, clk, rst_n, div_done && state_reg == rsm_pkg::ST_DIV,
        state_reg == rsm_pkg::ST_EMIT, "no emit after reciprocal")
endmodule

// ----- rtl/row_softmax_causal_mask.sv -----
// Row softmax with causal mask. Scores of one row are taken one per cycle
// into a 64-entry store; input stalls while the row is processed. After the
// last score the back end runs a max pass and a sum pass over the counted
// scores, a reciprocal by a bit-serial divider, then emits one probability
// per loaded score, reading each further score only once the previous result
// is buffered. Config at byte 0 is causal_mask, at byte 4 past_length.
module row_softmax_causal_mask #(
    parameter int MAX_LEN         = rsm_pkg::MAX_LEN_DEF,
    parameter int EXP_TABLE_DEPTH = rsm_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rsm_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    rsm_stream_if.sink                  in_ch,
    rsm_stream_if.source                out_ch
);
    localparam int AW = $clog2(MAX_LEN);

    logic                       causal_mask_reg;
    logic [rsm_pkg::PAST_W-1:0] past_length_reg;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [rsm_pkg::SCORE_W-1:0] wr_data;
    logic [AW-1:0]              rd_addr;
    logic [rsm_pkg::SCORE_W-1:0] rd_data;
    logic                       desc_valid;
    rsm_pkg::row_desc_t         desc;
    logic                       back_busy;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            causal_mask_reg <= 1'b0;
            past_length_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr)
                rsm_pkg::REG_CAUSAL_MASK: causal_mask_reg <= pwdata[0];
                rsm_pkg::REG_PAST_LENGTH: past_length_reg <= pwdata[rsm_pkg::PAST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            rsm_pkg::REG_CAUSAL_MASK: prdata = 32'(causal_mask_reg);
            rsm_pkg::REG_PAST_LENGTH: prdata = 32'(past_length_reg);
            default: prdata = '0;
        endcase
    end

    rsm_front #(.MAX_LEN(MAX_LEN)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .causal_mask (causal_mask_reg),
        .past_length (past_length_reg),
        .in_valid    (in_ch.valid),
        .in_ready    (in_ch.ready),
        .score       (in_ch.data[15:0]),
        .row_index   (in_ch.data[21:16]),
        .last        (in_ch.data[22]),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .desc_valid  (desc_valid),
        .desc        (desc),
        .back_busy   (back_busy)
    );

    rsm_ram #(.WIDTH(rsm_pkg::SCORE_W), .DEPTH(MAX_LEN)) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    rsm_back #(.MAX_LEN(MAX_LEN), .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (desc_valid),
        .desc       (desc),
        .busy       (back_busy),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .out_ch     (out_ch)
    );
endmodule

// ----- verif/tb_row_softmax_causal_mask.sv -----
`default_nettype none

module tb_row_softmax_causal_mask;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_LEN     = 64;
    localparam int TABLE_DEPTH = 256;
    localparam int STALL_LIMIT = 20000;
    localparam int IN_W        = rsm_pkg::SCORE_W + rsm_pkg::ROW_W + 1;

    typedef struct {
        logic [rsm_pkg::PROB_W-1:0] probability;
        logic                       last_res;
    } prob_t;

    typedef struct {
        logic signed [rsm_pkg::SCORE_W-1:0] score;
        logic [rsm_pkg::ROW_W-1:0]          row_index;
        logic                               last;
        logic                               typed;
        logic [rsm_pkg::PROB_W-1:0]         typed_prob;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [rsm_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    rsm_stream_if #(.DATA_W(IN_W)) in_ch();
    rsm_stream_if #(.DATA_W(rsm_pkg::PROB_W + 1)) out_ch();

    row_softmax_causal_mask uut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    // predictor state
    logic [rsm_pkg::PROB_W-1:0] exp_lut [TABLE_DEPTH];
    logic [rsm_pkg::SCORE_W-1:0] row_scores [ROW_LEN];
    int unsigned loaded;
    logic mask_on;
    logic [rsm_pkg::PAST_W-1:0] past_len;

    prob_t prob_q[$];
    int errors;
    int stall_cycles;
    int src_idle;
    int snk_idle;
    int hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        logic [95:0] p;
        logic [95:0] e;
        p = 96'd1 << 32;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            e = (p + 96'd32768) >> 16;
            exp_lut[i] = (e > 96'd65535) ? 16'hFFFF : e[15:0];
            p = (p * 96'd4034748383 + (96'd1 << 31)) >> 32;
        end
    end

    function automatic logic [rsm_pkg::PROB_W-1:0] exp_of(
        logic signed [rsm_pkg::SCORE_W-1:0] s, int signed peak);
        int unsigned idx;
        if (s == rsm_pkg::MINUS_INF)
            return '0;
        idx = (peak - int'(s)) >> 4;
        if (idx >= TABLE_DEPTH)
            return '0;
        return exp_lut[idx];
    endfunction

    task automatic predict_softmax(logic signed [rsm_pkg::SCORE_W-1:0] s,
                                   logic [rsm_pkg::ROW_W-1:0] ri, logic lst);
        int unsigned n;
        int unsigned counted;
        int unsigned lim;
        int signed peak;
        logic [63:0] total;
        logic [63:0] recip;
        logic [63:0] pr;
        prob_t r;
        if (loaded < ROW_LEN)
        begin
            row_scores[loaded] = s;
            loaded++;
        end
        if (!lst)
            return;
        n = loaded;
        counted = n;
        if (mask_on)
        begin
            lim = ri + 1 + past_len;
            if (lim < counted)
                counted = lim;
        end
        peak = int'(rsm_pkg::MINUS_INF);
        for (int i = 0; i < counted; i++)
            if (int'($signed(row_scores[i])) > peak)
                peak = int'($signed(row_scores[i]));
        total = 0;
        for (int i = 0; i < counted; i++)
            total += exp_of($signed(row_scores[i]), peak);
        total &= 64'h7FFFFF;
        recip = (total != 0) ? ((64'd1 << 32) / total) : 0;
        for (int i = 0; i < n; i++)
        begin
            pr = 0;
            if (i < counted && total != 0)
            begin
                pr = (exp_of($signed(row_scores[i]), peak) * recip + 64'd32768) >> 16;
                if (pr > 64'd65535)
                    pr = 64'd65535;
            end
            r.probability = pr[15:0];
            r.last_res = (i + 1 == n);
            prob_q.push_back(r);
        end
        loaded = 0;
    endtask

    task automatic apb_write(logic [rsm_pkg::ADDR_W-1:0] addr, logic [31:0] value);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = addr;
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        stall_cycles = 0;
        if (addr == rsm_pkg::REG_CAUSAL_MASK)
            mask_on = value[0];
        else if (addr == rsm_pkg::REG_PAST_LENGTH)
            past_len = value[rsm_pkg::PAST_W-1:0];
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_score(logic signed [rsm_pkg::SCORE_W-1:0] s,
                              logic [rsm_pkg::ROW_W-1:0] ri, logic lst);
        while ($urandom_range(99) < src_idle)
        begin
            in_ch.valid = 1'b0;
            in_ch.data = IN_W'($urandom);
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data = {lst, ri, s};
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        stall_cycles = 0;
        predict_softmax(s, ri, lst);
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic configure(logic mask, logic [rsm_pkg::PAST_W-1:0] past);
        wait (prob_q.size() == 0);
        repeat (20) @(posedge clk);
        apb_write(rsm_pkg::REG_CAUSAL_MASK, {31'd0, mask});
        apb_write(rsm_pkg::REG_PAST_LENGTH, {26'd0, past});
    endtask

    task automatic random_row(int len);
        logic signed [rsm_pkg::SCORE_W-1:0] base;
        logic signed [rsm_pkg::SCORE_W-1:0] s;
        base = 16'($urandom);
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(9))
                0: s = rsm_pkg::MINUS_INF;
                1, 2: s = 16'($urandom);
                default: s = base - $signed({1'b0, 15'($urandom_range(4095))});
            endcase
            send_score(s, 6'($urandom_range(63)), i == len - 1);
        end
    endtask

    // result side
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            out_ch.ready = 1'b0;
        end
        else
            out_ch.ready = ($urandom_range(99) >= snk_idle);
    end

    always @(posedge clk)
    begin
        prob_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            stall_cycles = 0;
            if (prob_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected probability %0d last %0b",
                             out_ch.data[rsm_pkg::PROB_W-1:0],
                             out_ch.data[rsm_pkg::PROB_W]);
            end
            else
            begin
                want = prob_q.pop_front();
                if (out_ch.data[rsm_pkg::PROB_W-1:0] !== want.probability
                    || out_ch.data[rsm_pkg::PROB_W] !== want.last_res)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp prob %0d last %0b, got prob %0d last %0b",
                                 want.probability, want.last_res,
                                 out_ch.data[rsm_pkg::PROB_W-1:0],
                                 out_ch.data[rsm_pkg::PROB_W]);
                end
            end
        end
    end

    // watchdog on requests moving
    always @(posedge clk)
    begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_row_softmax_causal_mask failed");
            $finish;
        end
    end

    stim_row_t directed[$];

    initial
    begin
        stim_row_t d;
        int sent;
        int len;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        stall_cycles = 0;
        hold_cycles = 0;
        loaded = 0;
        mask_on = 1'b0;
        past_len = '0;
        src_idle = 12;
        snk_idle = 47;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // score, row, last, typed, value
        directed = '{
            '{16'sh7FFF, 6'd0,  1'b1, 1'b1, 16'hFFFF},
            '{rsm_pkg::MINUS_INF, 6'd0,  1'b1, 1'b1, 16'h0000},
            '{16'sh0000, 6'd0,  1'b0, 1'b0, 16'h0000},
            '{rsm_pkg::MINUS_INF, 6'd0,  1'b1, 1'b1, 16'h0000},
            '{16'sh7FFF, 6'd0,  1'b0, 1'b0, 16'h0000},
            '{16'sh8001, 6'd0,  1'b1, 1'b1, 16'h0000},
            '{16'sh5555, 6'd63, 1'b0, 1'b0, 16'h0000},
            '{16'shAAAA, 6'd42, 1'b1, 1'b0, 16'h0000},
            '{16'sh0100, 6'd21, 1'b0, 1'b0, 16'h0000},
            '{16'sh0100, 6'd0,  1'b0, 1'b0, 16'h0000},
            '{16'sh00F0, 6'd0,  1'b1, 1'b0, 16'h0000}
        };
        @(negedge clk);
        foreach (directed[i])
        begin
            d = directed[i];
            send_score(d.score, d.row_index, d.last);
            if (d.typed)
                prob_q[prob_q.size() - 1].probability = d.typed_prob;
        end

        // causal limit: row 1 with no past counts two of four
        configure(1'b1, 6'd0);
        @(negedge clk);
        send_score(16'sh0200, 6'd0, 1'b0);
        send_score(16'sh0100, 6'd0, 1'b0);
        send_score(16'sh7FFF, 6'd0, 1'b0);
        send_score(16'sh7FFF, 6'd1, 1'b1);
        // limit past the row saturates
        configure(1'b1, 6'd63);
        @(negedge clk);
        send_score(16'sh0040, 6'd0, 1'b0);
        send_score(16'sh0000, 6'd63, 1'b1);

        sent = 0;
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: configure(1'b0, 6'd0);
                1: configure(1'b1, 6'd0);
                2: configure(1'b1, 6'($urandom_range(63)));
                3: configure(1'b0, 6'd63);
                4: configure(1'b1, 6'd63);
                default: configure(1'b1, 6'($urandom_range(7)));
            endcase
            if (ph == 2)
            begin
                src_idle = 47;
                snk_idle = 12;
            end
            else if (ph == 4)
            begin
                src_idle = 0;
                snk_idle = 0;
            end
            @(negedge clk);
            if (ph == 1)
                hold_cycles = 400;
            while (sent < (ph + 1) * 70)
            begin
                case ($urandom_range(19))
                    0: len = $urandom_range(60, 68);
                    1, 2: len = $urandom_range(13, 30);
                    default: len = $urandom_range(1, 12);
                endcase
                random_row(len);
                sent += len;
            end
        end

        wait (prob_q.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0 && prob_q.size() == 0)
            $display("tb_row_softmax_causal_mask passed");
        else
            $display("tb_row_softmax_causal_mask failed");
        $finish;
    end
endmodule

`default_nettype wire
